[hdl/lpad_pkg.sv]
// Package for the length-prefixed Adler-32 deframer.
// Holds frame constants, register indexes, status codes and the phase type.
// No dependencies.
`default_nettype none
package lpad_pkg;

  localparam int unsigned HEADER_BYTES  = 4;
  localparam int unsigned CHECK_BYTES   = 4;
  localparam int unsigned MAX_TAG_BYTES = 8;

  localparam logic [16:0] ADLER_MOD = 17'd65521;

  localparam logic [3:0]  TAG_LEN_MAX = 4'(MAX_TAG_BYTES);
  localparam logic [30:0] HDR_LAST    = 31'(HEADER_BYTES - 1);
  localparam logic [31:0] CHECK_LEN   = 32'(CHECK_BYTES);

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAG_VALUE  = 2'd0,
    REG_TAG_LENGTH = 2'd1,
    REG_MIN_LENGTH = 2'd2,
    REG_MAX_LENGTH = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_LENGTH  = 2'd1,
    ST_BAD_CHECK   = 2'd2,
    ST_UNKNOWN_TAG = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_HALT   = 2'd2
  } phase_t;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

endpackage
`default_nettype wire

[hdl/length_prefixed_adler32_deframer_core.sv]
// Top level of the length-prefixed Adler-32 deframer: byte parser, running
// checksum, tag compare and one output register. Depends on lpad_pkg.
//
// Takes one stream byte per cycle and sustains one item per cycle: every byte
// is worked on in the cycle it is accepted and any result lands in a single
// output register, so in_ready is low only while that register holds an
// unread result and out_ready is low. Payload bytes come out in the cycle after
// they enter; the frame verdict comes in the cycle after the last check byte.
// A bad length header yields an invalid-length verdict and the block then
// drops all further bytes until reset; register writes are always taken.
`default_nettype none
module length_prefixed_adler32_deframer_core
  import lpad_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           in_data_byte,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_result_kind,
  output logic [7:0]                out_payload_byte,
  output logic [1:0]                out_status,
  output logic [31:0]               out_frame_length,
  output logic [31:0]               out_computed_checksum,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]          cfg_data
);

  logic [63:0] tag_value_r;
  logic [3:0]  tag_length_r;
  logic [30:0] min_length_r;
  logic [30:0] max_length_r;

  phase_t      phase_r, phase_nxt;
  logic [30:0] byte_count_r, byte_count_nxt;
  logic [31:0] length_r, length_nxt;
  logic [15:0] sum_low_r, sum_low_nxt;
  logic [15:0] sum_high_r, sum_high_nxt;
  logic [31:0] recv_sum_r, recv_sum_nxt;
  logic        tag_match_r, tag_match_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        kind_r, kind_nxt;
  logic [7:0]  pbyte_r, pbyte_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [31:0] flen_r, flen_nxt;
  logic [31:0] csum_r, csum_nxt;

  logic        in_fire;
  logic [3:0]  tl;
  logic [31:0] hdr_len;
  logic        hdr_done;
  logic        len_bad;
  logic [31:0] data_len;
  logic        in_data;
  logic        in_tag;
  logic        frame_end;
  logic [16:0] sl_sum;
  logic [15:0] sl_new;
  logic [16:0] sh_sum;
  logic [15:0] sh_new;
  logic [3:0]  tag_idx;
  logic [7:0]  tag_want;
  logic [31:0] comp_sum;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_value_r  <= '0;
      tag_length_r <= '0;
      min_length_r <= 31'd8;
      max_length_r <= 31'd67108864;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_TAG_VALUE:  tag_value_r  <= cfg_data;
        REG_TAG_LENGTH: tag_length_r <= cfg_data[3:0];
        REG_MIN_LENGTH: min_length_r <= cfg_data[30:0];
        REG_MAX_LENGTH: max_length_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Datapath terms
  always_comb begin
    tl       = (tag_length_r > TAG_LEN_MAX) ? TAG_LEN_MAX : tag_length_r;
    hdr_len  = {length_r[23:0], in_data_byte};
    hdr_done = (byte_count_r == HDR_LAST);
    len_bad  = hdr_len[31]
            || (hdr_len < {1'b0, min_length_r})
            || (hdr_len > {1'b0, max_length_r})
            || (hdr_len < ({28'd0, tl} + CHECK_LEN));
    data_len  = length_r - CHECK_LEN;
    in_data   = ({1'b0, byte_count_r} < data_len);
    in_tag    = (byte_count_r < {27'd0, tl});
    frame_end = (({1'b0, byte_count_r} + 32'd1) == length_r);
    sl_sum = {1'b0, sum_low_r} + {9'd0, in_data_byte};
    sl_new = (sl_sum >= ADLER_MOD) ? 16'(sl_sum - ADLER_MOD) : sl_sum[15:0];
    sh_sum = {1'b0, sum_high_r} + {1'b0, sl_new};
    sh_new = (sh_sum >= ADLER_MOD) ? 16'(sh_sum - ADLER_MOD) : sh_sum[15:0];
    tag_idx  = tl - 4'd1 - byte_count_r[3:0];
    tag_want = tag_value_r[{tag_idx[2:0], 3'b000} +: 8];
    comp_sum = {sum_high_r, sum_low_r};
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (in_fire) begin
      case (phase_r)
        PH_HEADER: if (hdr_done) phase_nxt = len_bad ? PH_HALT : PH_BODY;
        PH_BODY:   if (!in_data && frame_end) phase_nxt = PH_HEADER;
        PH_HALT:   phase_nxt = PH_HALT;
        default:   phase_nxt = PH_HALT;
      endcase
    end
  end

  // Frame state and results
  always_comb begin
    byte_count_nxt = byte_count_r;
    length_nxt     = length_r;
    sum_low_nxt    = sum_low_r;
    sum_high_nxt   = sum_high_r;
    recv_sum_nxt   = recv_sum_r;
    tag_match_nxt  = tag_match_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    kind_nxt       = kind_r;
    pbyte_nxt      = pbyte_r;
    status_nxt     = status_r;
    flen_nxt       = flen_r;
    csum_nxt       = csum_r;
    if (in_fire) begin
      case (phase_r)
        PH_HEADER: begin
          length_nxt     = hdr_len;
          byte_count_nxt = hdr_done ? '0 : byte_count_r + 31'd1;
          if (hdr_done && len_bad) begin
            out_valid_nxt = 1'b1;
            kind_nxt      = KIND_VERDICT;
            pbyte_nxt     = '0;
            status_nxt    = ST_BAD_LENGTH;
            flen_nxt      = hdr_len;
            csum_nxt      = '0;
          end
        end
        PH_BODY: begin
          byte_count_nxt = byte_count_r + 31'd1;
          if (in_data) begin
            sum_low_nxt  = sl_new;
            sum_high_nxt = sh_new;
            if (in_tag) begin
              if (tag_want != in_data_byte) tag_match_nxt = 1'b0;
            end else begin
              out_valid_nxt = 1'b1;
              kind_nxt      = KIND_PAYLOAD;
              pbyte_nxt     = in_data_byte;
              status_nxt    = ST_OK;
              flen_nxt      = length_r;
              csum_nxt      = '0;
            end
          end else begin
            recv_sum_nxt = {recv_sum_r[23:0], in_data_byte};
            if (frame_end) begin
              out_valid_nxt = 1'b1;
              kind_nxt      = KIND_VERDICT;
              pbyte_nxt     = '0;
              flen_nxt      = length_r;
              csum_nxt      = comp_sum;
              if (comp_sum != recv_sum_nxt) status_nxt = ST_BAD_CHECK;
              else if (!tag_match_r)        status_nxt = ST_UNKNOWN_TAG;
              else                          status_nxt = ST_OK;
              byte_count_nxt = '0;
              length_nxt     = '0;
              sum_low_nxt    = 16'd1;
              sum_high_nxt   = '0;
              recv_sum_nxt   = '0;
              tag_match_nxt  = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      byte_count_r <= '0;
      length_r     <= '0;
      sum_low_r    <= 16'd1;
      sum_high_r   <= '0;
      recv_sum_r   <= '0;
      tag_match_r  <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      byte_count_r <= byte_count_nxt;
      length_r     <= length_nxt;
      sum_low_r    <= sum_low_nxt;
      sum_high_r   <= sum_high_nxt;
      recv_sum_r   <= recv_sum_nxt;
      tag_match_r  <= tag_match_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    pbyte_r  <= pbyte_nxt;
    status_r <= status_nxt;
    flen_r   <= flen_nxt;
    csum_r   <= csum_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_result_kind       = kind_r;
  assign out_payload_byte      = pbyte_r;
  assign out_status            = status_r;
  assign out_frame_length      = flen_r;
  assign out_computed_checksum = csum_r;

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HALT |=> phase_r == PH_HALT)
    else $error("left halt without reset");

  a_sums_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, sum_low_r} < ADLER_MOD) && ({1'b0, sum_high_r} < ADLER_MOD))
    else $error("checksum sums not reduced");

  a_hdr_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HEADER |-> byte_count_r <= HDR_LAST)
    else $error("header byte count overrun");

  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HALT && !out_valid_r) |=> !out_valid_r)
    else $error("result while halted");

  a_bad_len_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_BAD_LENGTH) |-> (kind_r == KIND_VERDICT
      && csum_r == '0 && phase_r == PH_HALT))
    else $error("malformed invalid-length verdict");

endmodule
`default_nettype wire

[tb/length_prefixed_adler32_deframer_core_tb.sv]
// Testbench for length_prefixed_adler32_deframer_core: drives byte frames with random
// gaps and result stalls, predicts every forwarded byte and verdict, checks them in order.
// Depends on lpad_pkg and the deframer core.
`timescale 1ns / 100ps
module length_prefixed_adler32_deframer_core_tb;
  import lpad_pkg::*;

  localparam int unsigned QUIET_LIMIT = 1000;

  class deframe_tracker;
    typedef struct packed {
      logic        kind;
      logic [7:0]  data;
      status_t     status;
      logic [31:0] length;
      logic [31:0] checksum;
    } frame_item_t;

    logic [63:0] tag_value;
    logic [3:0]  tag_len;
    logic [30:0] min_len;
    logic [30:0] max_len;
    phase_t      phase;
    logic [31:0] count;
    logic [31:0] frame_len;
    logic [31:0] rx_sum;
    logic [15:0] sum_a;
    logic [15:0] sum_b;
    bit          tag_ok;
    frame_item_t pending[$];
    int          errors;

    function new();
      tag_value = '0;
      tag_len   = '0;
      min_len   = 31'd8;
      max_len   = 31'd67108864;
      errors    = 0;
      restart();
    endfunction

    function void restart();
      phase     = PH_HEADER;
      count     = '0;
      frame_len = '0;
      rx_sum    = '0;
      sum_a     = 16'd1;
      sum_b     = '0;
      tag_ok    = 1'b1;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [63:0] d);
      case (idx)
        REG_TAG_VALUE:  tag_value = d;
        REG_TAG_LENGTH: tag_len = d[3:0];
        REG_MIN_LENGTH: min_len = d[30:0];
        REG_MAX_LENGTH: max_len = d[30:0];
        default: ;
      endcase
    endfunction

    function int unsigned tag_bytes();
      return (tag_len > TAG_LEN_MAX) ? MAX_TAG_BYTES : int'(tag_len);
    endfunction

    function logic [31:0] checksum();
      return {sum_b, sum_a};
    endfunction

    function void push(logic kind, logic [7:0] d, status_t st, logic [31:0] fl,
                       logic [31:0] cs);
      frame_item_t it;
      it.kind     = kind;
      it.data     = d;
      it.status   = st;
      it.length   = fl;
      it.checksum = cs;
      pending.push_back(it);
    endfunction

    function void take_byte(logic [7:0] b);
      int unsigned tl;
      logic [31:0] k;
      logic [16:0] s;
      logic [63:0] shifted;
      status_t     st;
      tl = tag_bytes();
      case (phase)
        PH_HEADER: begin
          frame_len = {frame_len[23:0], b};
          count++;
          if (count == HEADER_BYTES) begin
            count = '0;
            if (frame_len[31] || frame_len < {1'b0, min_len} ||
                frame_len > {1'b0, max_len} || frame_len < tl + CHECK_BYTES) begin
              phase = PH_HALT;
              push(KIND_VERDICT, 8'h00, ST_BAD_LENGTH, frame_len, 32'h0);
            end else begin
              phase = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          k = count;
          count++;
          if (k < frame_len - CHECK_LEN) begin
            s = sum_a + b;
            if (s >= ADLER_MOD) s = s - ADLER_MOD;
            sum_a = s[15:0];
            s = sum_b + sum_a;
            if (s >= ADLER_MOD) s = s - ADLER_MOD;
            sum_b = s[15:0];
            if (k < tl) begin
              shifted = tag_value >> (8 * (tl - 1 - k));
              if (shifted[7:0] != b) tag_ok = 1'b0;
            end else begin
              push(KIND_PAYLOAD, b, ST_OK, frame_len, 32'h0);
            end
          end else begin
            rx_sum = {rx_sum[23:0], b};
            if (count == frame_len) begin
              if (checksum() != rx_sum) st = ST_BAD_CHECK;
              else if (!tag_ok) st = ST_UNKNOWN_TAG;
              else st = ST_OK;
              push(KIND_VERDICT, 8'h00, st, frame_len, checksum());
              restart();
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, what, want, got);
      errors++;
    endfunction

    function void check_result(logic kind, logic [7:0] pb, logic [1:0] st,
                               logic [31:0] fl, logic [31:0] cs);
      frame_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected item, expected none actual kind %0d status %0d",
                 $time, kind, st);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (kind !== want.kind) flag("result_kind", want.kind, kind);
      if (pb !== want.data) flag("payload_byte", want.data, pb);
      if (st !== want.status) flag("status", want.status, st);
      if (fl !== want.length) flag("frame_length", want.length, fl);
      if (cs !== want.checksum) flag("computed_checksum", want.checksum, cs);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_data_byte = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_result_kind;
  logic [7:0]           out_payload_byte;
  logic [1:0]           out_status;
  logic [31:0]          out_frame_length;
  logic [31:0]          out_computed_checksum;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]          cfg_data = '0;

  deframe_tracker tracker = new();
  bit             in_calm = 1'b0;
  bit             out_calm = 1'b0;
  int unsigned    bytes_sent = 0;
  int unsigned    quiet = 0;

  length_prefixed_adler32_deframer_core dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_data_byte          (in_data_byte),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_result_kind       (out_result_kind),
    .out_payload_byte      (out_payload_byte),
    .out_status            (out_status),
    .out_frame_length      (out_frame_length),
    .out_computed_checksum (out_computed_checksum),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (out_valid === 1'b1 && out_ready) begin
      tracker.check_result(out_result_kind, out_payload_byte, out_status,
                           out_frame_length, out_computed_checksum);
    end
  end

  always @(negedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("length_prefixed_adler32_deframer_core_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin : result_sink
    int unsigned gap;
    bit seen;
    forever begin
      if ($urandom_range(0, 15) == 0) out_calm = !out_calm;
      gap = out_calm ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        seen = (out_valid === 1'b1);
        @(posedge clk);
      end while (!seen);
    end
  end

  task automatic send_byte(logic [7:0] b);
    int unsigned gap;
    bit took;
    gap = in_calm ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    do begin
      @(negedge clk);
      took = (in_ready === 1'b1);
      @(posedge clk);
    end while (!took);
    tracker.take_byte(b);
    bytes_sent++;
  endtask

  task automatic send_word(logic [31:0] w);
    for (int i = 3; i >= 0; i--) send_byte(w[8*i +: 8]);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [63:0] d);
    bit took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do begin
      @(negedge clk);
      took = (cfg_ready === 1'b1);
      @(posedge clk);
    end while (!took);
    tracker.set_reg(idx, d);
  endtask

  // unused upper bits of the tag length and length limit writes carry noise
  task automatic program_regs(logic [63:0] tv, logic [3:0] tl, logic [30:0] mn,
                              logic [30:0] mx);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    write_reg(REG_TAG_VALUE, tv);
    write_reg(REG_TAG_LENGTH, {junk[63:4], tl});
    write_reg(REG_MIN_LENGTH, {junk[63:31], mn});
    write_reg(REG_MAX_LENGTH, {junk[63:31], mx});
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic send_frame(int unsigned lo, int unsigned hi, bit tag_bad, bit sum_bad);
    int unsigned tl, body, fill, bad_pos, r;
    logic [63:0] shifted;
    logic [31:0] sum;
    logic [7:0]  b;
    if ($urandom_range(0, 3) == 0) in_calm = !in_calm;
    tl = tracker.tag_bytes();
    if (lo < tl + CHECK_BYTES) lo = tl + CHECK_BYTES;
    r = $urandom_range(0, 29);
    if (r == 0) body = $urandom_range(270, 310);
    else if (r < 3) body = lo;
    else if (r < 5) body = hi;
    else body = lo + $urandom_range(0, 24);
    if (body > hi) body = hi;
    send_word(body);
    bad_pos = (tl > 0) ? $urandom_range(0, tl - 1) : 0;
    for (int unsigned i = 0; i < tl; i++) begin
      shifted = tracker.tag_value >> (8 * (tl - 1 - i));
      b = shifted[7:0];
      if (tag_bad && i == bad_pos) b = b ^ 8'($urandom_range(1, 255));
      send_byte(b);
    end
    fill = (body >= 270) ? 1 : $urandom_range(0, 3);
    for (int unsigned i = 0; i < body - CHECK_BYTES - tl; i++) begin
      case (fill)
        1: b = 8'hFF;
        2: b = i[0] ? 8'h00 : 8'hFF;
        default: b = 8'($urandom);
      endcase
      send_byte(b);
    end
    sum = tracker.checksum();
    if (sum_bad) sum = sum ^ (32'h1 << $urandom_range(0, 31));
    send_word(sum);
  endtask

  initial begin : stimulus
    int unsigned start, hi, kind, len;
    logic [30:0] mn, mx;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: no tag, shortest legal frame
    send_word(32'd8);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_word(tracker.checksum());
    settle();
    program_regs(64'hA5C3, 4'd2, 31'd0, 31'h7FFF_FFFF);
    send_frame(0, 6, 1'b0, 1'b0);
    send_frame(0, 7, 1'b1, 1'b0);
    send_frame(0, 7, 1'b0, 1'b1);
    send_frame(0, 7, 1'b1, 1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: program_regs({$urandom, $urandom}, 4'd0, 31'd0, 31'h7FFF_FFFF);
        1: program_regs(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 31'd12, 31'd40);
        2: program_regs({$urandom, $urandom}, 4'($urandom_range(9, 15)),
                        31'($urandom_range(0, 12)), 31'h7FFF_FFFF);
        3: program_regs({$urandom, $urandom}, 4'($urandom_range(1, 7)),
                        31'($urandom_range(0, 11)), 31'($urandom_range(40, 400)));
        4: program_regs(64'h0, 4'd8, 31'd0, 31'd300);
        default: program_regs({$urandom, $urandom}, 4'($urandom_range(0, 15)),
                              31'($urandom_range(0, 12)), 31'($urandom_range(60, 1000)));
      endcase
      hi = (tracker.max_len > 320) ? 320 : tracker.max_len;
      start = bytes_sent;
      while (bytes_sent - start < 220) begin
        send_frame(tracker.min_len, hi, $urandom_range(0, 5) == 0,
                   $urandom_range(0, 6) == 0);
      end
    end

    // one bad length per run, since the block halts until reset
    settle();
    kind = $urandom_range(0, 4);
    case (kind)
      0: begin
        program_regs({$urandom, $urandom}, 4'd2, 31'd0, 31'h7FFF_FFFF);
        len = 32'h8000_0000 | $urandom;
      end
      1: begin
        mn = $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd100;
        program_regs({$urandom, $urandom}, 4'($urandom_range(0, 8)), mn, 31'h7FFF_FFFF);
        len = $urandom_range(0, mn - 1);
      end
      2: begin
        mx = $urandom_range(0, 1) ? 31'd0 : 31'd50;
        program_regs({$urandom, $urandom}, 4'($urandom_range(0, 8)), 31'd0, mx);
        len = $urandom_range(mx + 1, 32'h7FFF_FFFF);
      end
      3: begin
        program_regs({$urandom, $urandom}, 4'd8, 31'd0, 31'h7FFF_FFFF);
        len = $urandom_range(0, 11);
      end
      default: begin
        program_regs({$urandom, $urandom}, 4'($urandom_range(0, 8)), 31'd200, 31'd100);
        len = $urandom_range(0, 300);
      end
    endcase
    send_word(len);
    settle();
    program_regs({$urandom, $urandom}, 4'd0, 31'd0, 31'h7FFF_FFFF);
    repeat (20) send_byte(8'($urandom));

    settle();
    repeat (4) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("length_prefixed_adler32_deframer_core_tb: PASS");
    end else begin
      $display("length_prefixed_adler32_deframer_core_tb: FAIL");
    end
    $finish;
  end

endmodule
